// ===== src/ugl_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with glyph lookup.
package ugl_pkg;

  localparam int CpW            = 21;
  localparam int IdxW           = 16;
  localparam int CfgAddrW       = 4;
  localparam int ExtraRanges    = 2;
  localparam int GlyphIndexBits = 16;

  localparam logic [IdxW-1:0] IdxMask =
    IdxW'((32'd1 << GlyphIndexBits) - 32'd1);

  // register indexes
  localparam logic [CfgAddrW-1:0] RegPrimaryFirst = 4'd0;
  localparam logic [CfgAddrW-1:0] RegPrimaryLast  = 4'd1;
  localparam logic [CfgAddrW-1:0] RegRangeAFirst  = 4'd2;
  localparam logic [CfgAddrW-1:0] RegRangeALast   = 4'd3;
  localparam logic [CfgAddrW-1:0] RegRangeABase   = 4'd4;
  localparam logic [CfgAddrW-1:0] RegRangeBFirst  = 4'd5;
  localparam logic [CfgAddrW-1:0] RegRangeBLast   = 4'd6;
  localparam logic [CfgAddrW-1:0] RegRangeBBase   = 4'd7;

  // byte classes
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;
  localparam logic [7:0] Lead2Bits = 8'h1F;
  localparam logic [7:0] Lead3Bits = 8'h0F;
  localparam logic [7:0] Lead4Bits = 8'h07;

  localparam logic [CpW-1:0] CharLowA  = CpW'(97);
  localparam logic [CpW-1:0] CharLowZ  = CpW'(122);
  localparam logic [CpW-1:0] CaseShift = CpW'(32);

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           text_end;
    logic           last_of_run;
  } ugl_entry_t;

  typedef struct packed {
    logic [CpW-1:0]             primary_first;
    logic [CpW-1:0]             primary_last;
    logic [1:0][CpW-1:0]        range_first;
    logic [1:0][CpW-1:0]        range_last;
    logic [1:0][IdxW-1:0]       range_base;
  } ugl_cfg_t;

endpackage

// ===== src/ugl_ifs.sv =====
// Channel interfaces: text bytes in, glyph results out, register writes.
interface ugl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ugl_glyph_if;
  logic                     valid;
  logic                     ready;
  logic [ugl_pkg::CpW-1:0]  code_point;
  logic                     glyph_found;
  logic [ugl_pkg::IdxW-1:0] glyph_index;
  logic                     text_end;
  logic                     last_of_run;
  modport source (output valid, output code_point, output glyph_found,
                  output glyph_index, output text_end, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input glyph_found,
                  input glyph_index, input text_end, input last_of_run,
                  output ready);
endinterface

interface ugl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ugl_pkg::CfgAddrW-1:0] index;
  logic [ugl_pkg::CpW-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ugl_front.sv =====
// Byte decoder: tracks partial sequences and queues codepoint entries.
module ugl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  ugl_byte_if.sink            byte_i,
  output logic                push_valid_o,
  output ugl_pkg::ugl_entry_t push_entry_o,
  input  logic                push_ready_i
);

  logic [1:0]                  pend_q, pend_d;
  logic [ugl_pkg::CpW-1:0]     pv_q, pv_d;
  logic                        hold_q, hold_d;
  ugl_pkg::ugl_entry_t         hold_e_q, hold_e_d;

  logic                        accept;
  logic                        is_cont;
  logic                        flush_v, fresh_v;
  ugl_pkg::ugl_entry_t         flush_e, fresh_e;
  logic [ugl_pkg::CpW-1:0]     pv_shift;
  logic [ugl_pkg::CpW-1:0]     raw_cp;
  logic [7:0]                  b;

  assign b            = byte_i.text_byte;
  assign byte_i.ready = !hold_q && push_ready_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign is_cont      = (b & ugl_pkg::ContMask) == ugl_pkg::ContTag;
  assign pv_shift     = {pv_q[ugl_pkg::CpW-7:0], b[5:0]};
  assign raw_cp       = ugl_pkg::CpW'(b);

  always_comb begin
    pend_d  = pend_q;
    pv_d    = pv_q;
    flush_v = (pend_q != 2'd0) && !is_cont;
    fresh_v = 1'b0;
    fresh_e = '{code_point: '0, text_end: 1'b0, last_of_run: 1'b1};
    if ((pend_q != 2'd0) && is_cont) begin
      pend_d = pend_q - 2'd1;
      if (pend_q == 2'd1) begin
        fresh_v            = 1'b1;
        fresh_e.code_point = pv_shift;
        pv_d               = '0;
      end else begin
        pv_d = pv_shift;
      end
    end else begin
      pend_d = 2'd0;
      pv_d   = '0;
      if (b == 8'd0) begin
        fresh_v          = 1'b1;
        fresh_e.text_end = 1'b1;
      end else if (!b[7]) begin
        fresh_v            = 1'b1;
        fresh_e.code_point = raw_cp;
      end else if ((b & ugl_pkg::Lead2Mask) == ugl_pkg::Lead2Tag) begin
        pv_d   = ugl_pkg::CpW'(b & ugl_pkg::Lead2Bits);
        pend_d = 2'd1;
      end else if ((b & ugl_pkg::Lead3Mask) == ugl_pkg::Lead3Tag) begin
        pv_d   = ugl_pkg::CpW'(b & ugl_pkg::Lead3Bits);
        pend_d = 2'd2;
      end else if ((b & ugl_pkg::Lead4Mask) == ugl_pkg::Lead4Tag) begin
        pv_d   = ugl_pkg::CpW'(b & ugl_pkg::Lead4Bits);
        pend_d = 2'd3;
      end else begin
        fresh_v            = 1'b1;
        fresh_e.code_point = raw_cp;
      end
    end
    flush_e = '{code_point: pv_q, text_end: 1'b0, last_of_run: !fresh_v};
  end

  always_comb begin
    hold_d   = hold_q;
    hold_e_d = hold_e_q;
    if (hold_q) begin
      push_valid_o = 1'b1;
      push_entry_o = hold_e_q;
      if (push_ready_i) hold_d = 1'b0;
    end else begin
      push_valid_o = accept && (flush_v || fresh_v);
      push_entry_o = flush_v ? flush_e : fresh_e;
      if (accept && flush_v && fresh_v) begin
        hold_d   = 1'b1;
        hold_e_d = fresh_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      pv_q   <= '0;
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
      if (accept) begin
        pend_q <= pend_d;
        pv_q   <= pv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_e_q <= hold_e_d;
  end

endmodule

// ===== src/ugl_fifo.sv =====
// Four-entry queue between the decoder and the lookup stage.
module ugl_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  ugl_pkg::ugl_entry_t push_entry_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output ugl_pkg::ugl_entry_t pop_entry_o,
  input  logic                pop_ready_i
);

  ugl_pkg::ugl_entry_t mem_q [4];
  logic [1:0]          wr_q, rd_q;
  logic [2:0]          cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q != 3'd4;
  assign pop_valid_o  = cnt_q != 3'd0;
  assign pop_entry_o  = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (do_push) wr_q <= wr_q + 2'd1;
      if (do_pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_entry_i;
  end

endmodule

// ===== src/ugl_back.sv =====
// Glyph lookup over the configured ranges, with a registered result.
module ugl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ugl_pkg::ugl_cfg_t   cfg_i,
  input  logic                pop_valid_i,
  input  ugl_pkg::ugl_entry_t pop_entry_i,
  output logic                pop_ready_o,
  ugl_glyph_if.source         glyph_o
);

  logic                       out_valid_q;
  logic [ugl_pkg::CpW-1:0]    cp_q;
  logic                       found_q, found_d;
  logic [ugl_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                       end_q, last_q;

  logic [ugl_pkg::CpW-1:0]    cp;
  logic [ugl_pkg::CpW-1:0]    up;
  logic [ugl_pkg::CpW-1:0]    diff;
  logic                       do_pop;

  assign cp          = pop_entry_i.code_point;
  assign up          = cp - ugl_pkg::CaseShift;
  assign pop_ready_o = !out_valid_q || glyph_o.ready;
  assign do_pop      = pop_valid_i && pop_ready_o;

  always_comb begin
    found_d = 1'b0;
    idx_d   = '0;
    diff    = '0;
    if (!pop_entry_i.text_end) begin
      if (cp >= cfg_i.primary_first && cp <= cfg_i.primary_last) begin
        found_d = 1'b1;
        diff    = cp - cfg_i.primary_first;
        idx_d   = diff[ugl_pkg::IdxW-1:0] & ugl_pkg::IdxMask;
      end else begin
        for (int r = ugl_pkg::ExtraRanges - 1; r >= 0; r--) begin
          if (cp >= cfg_i.range_first[r] && cp <= cfg_i.range_last[r]) begin
            found_d = 1'b1;
            diff    = cp - cfg_i.range_first[r];
            idx_d   = (cfg_i.range_base[r] + diff[ugl_pkg::IdxW-1:0]) & ugl_pkg::IdxMask;
          end
        end
        if (!found_d && cp >= ugl_pkg::CharLowA && cp <= ugl_pkg::CharLowZ
            && cfg_i.primary_last < ugl_pkg::CharLowA
            && up >= cfg_i.primary_first && up <= cfg_i.primary_last) begin
          found_d = 1'b1;
          diff    = up - cfg_i.primary_first;
          idx_d   = diff[ugl_pkg::IdxW-1:0] & ugl_pkg::IdxMask;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      cp_q    <= cp;
      found_q <= found_d;
      idx_q   <= idx_d;
      end_q   <= pop_entry_i.text_end;
      last_q  <= pop_entry_i.last_of_run;
    end
  end

  assign glyph_o.valid       = out_valid_q;
  assign glyph_o.code_point  = cp_q;
  assign glyph_o.glyph_found = found_q;
  assign glyph_o.glyph_index = idx_q;
  assign glyph_o.text_end    = end_q;
  assign glyph_o.last_of_run = last_q;

endmodule

// ===== src/utf8_decode_glyph_lookup.sv =====
// Top level: UTF-8 byte decoder feeding a glyph range lookup.
//
// byte_i carries one text byte per transfer; glyph_o carries one result
// per transfer (codepoint, glyph hit and index, end marker, last-of-byte
// flag); cfg_i writes the eight range registers by index, always ready,
// indexes above seven are dropped. Write registers only while idle.
//
// Bytes are taken one per cycle while the queue has room and no result is
// held. A byte that both flushes a partial sequence and yields a result of
// its own makes the decoder hold the second result and deassert byte_i.ready
// until the queue takes it. A completing byte's result is written to the
// queue, then registered by the lookup before it shows on glyph_o.
//
// Reset clears the decoder state, empties the four-entry queue and the
// output register, and loads the register reset values. When glyph_o
// stalls, the queue fills and byte_i.ready drops once it is full; no
// result is lost or repeated.
module utf8_decode_glyph_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  ugl_byte_if.sink    byte_i,
  ugl_glyph_if.source glyph_o,
  ugl_cfg_if.sink     cfg_i
);

  ugl_pkg::ugl_cfg_t   cfg_q;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  ugl_pkg::ugl_entry_t push_entry, pop_entry;
  logic [ugl_pkg::IdxW-1:0] wr_base;

  assign cfg_i.ready = 1'b1;
  assign wr_base     = cfg_i.data[ugl_pkg::IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.primary_first  <= ugl_pkg::CpW'(32);
      cfg_q.primary_last   <= ugl_pkg::CpW'(126);
      cfg_q.range_first[0] <= ugl_pkg::CpW'(1);
      cfg_q.range_last[0]  <= '0;
      cfg_q.range_base[0]  <= '0;
      cfg_q.range_first[1] <= ugl_pkg::CpW'(1);
      cfg_q.range_last[1]  <= '0;
      cfg_q.range_base[1]  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ugl_pkg::RegPrimaryFirst: cfg_q.primary_first  <= cfg_i.data;
        ugl_pkg::RegPrimaryLast:  cfg_q.primary_last   <= cfg_i.data;
        ugl_pkg::RegRangeAFirst:  cfg_q.range_first[0] <= cfg_i.data;
        ugl_pkg::RegRangeALast:   cfg_q.range_last[0]  <= cfg_i.data;
        ugl_pkg::RegRangeABase:   cfg_q.range_base[0]  <= wr_base;
        ugl_pkg::RegRangeBFirst:  cfg_q.range_first[1] <= cfg_i.data;
        ugl_pkg::RegRangeBLast:   cfg_q.range_last[1]  <= cfg_i.data;
        ugl_pkg::RegRangeBBase:   cfg_q.range_base[1]  <= wr_base;
        default: ;
      endcase
    end
  end

  ugl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  ugl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  ugl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .glyph_o     (glyph_o)
  );

endmodule

// ===== dv/utf8_decode_glyph_lookup_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 decoder with glyph lookup, directed and random text.
module utf8_decode_glyph_lookup_test;
  import ugl_pkg::*;

  localparam logic [CfgAddrW-1:0] RegUnused = 4'd15;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongStall     = 300;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned MaxGap        = 11;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic            glyph_found;
    logic [IdxW-1:0] glyph_index;
    logic            text_end;
    logic            last_of_run;
  } glyph_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ugl_byte_if  byte_ch ();
  ugl_glyph_if glyph_ch ();
  ugl_cfg_if   cfg_ch ();

  utf8_decode_glyph_lookup i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_ch),
    .glyph_o (glyph_ch),
    .cfg_i   (cfg_ch)
  );

  always #6 clk_i = ~clk_i;

  ugl_cfg_t       range_cfg;
  logic [1:0]     cont_left;
  logic [CpW-1:0] cp_accum;
  logic [7:0]     text_q[$];
  glyph_res_t     glyph_expect_q[$];
  int unsigned    errors = 0;
  bit             send_gaps_on = 1'b1;
  bit             recv_gaps_on = 1'b1;
  int unsigned    stall_requests = 0;
  int unsigned    stalls_served = 0;
  int unsigned    send_wait = 0;
  int unsigned    recv_wait = 0;
  int unsigned    hold_left = 0;
  int unsigned    quiet_cycles = 0;

  function automatic glyph_res_t glyph_of(logic [CpW-1:0] cp);
    glyph_res_t res;
    logic [CpW-1:0] upper;
    res = '0;
    res.code_point = cp;
    upper = cp - CaseShift;
    if (cp >= range_cfg.primary_first && cp <= range_cfg.primary_last) begin
      res.glyph_found = 1'b1;
      res.glyph_index = IdxW'(cp - range_cfg.primary_first) & IdxMask;
    end else begin
      for (int r = 0; r < ExtraRanges; r++) begin
        if (!res.glyph_found && cp >= range_cfg.range_first[r] &&
            cp <= range_cfg.range_last[r]) begin
          res.glyph_found = 1'b1;
          res.glyph_index = (range_cfg.range_base[r] + IdxW'(cp - range_cfg.range_first[r]))
                            & IdxMask;
        end
      end
      // lowercase folds onto uppercase only when the primary range stops below 'a'
      if (!res.glyph_found && cp >= CharLowA && cp <= CharLowZ &&
          range_cfg.primary_last < CharLowA &&
          upper >= range_cfg.primary_first && upper <= range_cfg.primary_last) begin
        res.glyph_found = 1'b1;
        res.glyph_index = IdxW'(upper - range_cfg.primary_first) & IdxMask;
      end
    end
    return res;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    glyph_res_t res[2];
    int n;
    bit handled;
    n = 0;
    handled = 1'b0;
    if (cont_left != 2'd0) begin
      if ((b & ContMask) == ContTag) begin
        handled = 1'b1;
        cp_accum = {cp_accum[CpW-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          res[n] = glyph_of(cp_accum);
          n++;
          cp_accum = '0;
        end
      end else begin
        // flush the partial codepoint, then treat the byte as fresh
        res[n] = glyph_of(cp_accum);
        n++;
        cont_left = '0;
        cp_accum = '0;
      end
    end
    if (!handled) begin
      if (b == 8'h00) begin
        res[n] = '0;
        res[n].text_end = 1'b1;
        n++;
      end else if (b[7] == 1'b0) begin
        res[n] = glyph_of(CpW'(b));
        n++;
      end else if ((b & Lead2Mask) == Lead2Tag) begin
        cp_accum = CpW'(b & Lead2Bits);
        cont_left = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Tag) begin
        cp_accum = CpW'(b & Lead3Bits);
        cont_left = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Tag) begin
        cp_accum = CpW'(b & Lead4Bits);
        cont_left = 2'd3;
      end else begin
        res[n] = glyph_of(CpW'(b));
        n++;
      end
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) glyph_expect_q.push_back(res[k]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.text_byte <= '0;
      send_wait = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.text_byte);
        send_wait = send_gaps_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (byte_ch.valid && !byte_ch.ready) begin
        // hold until the transfer completes
      end else if (send_wait > 0) begin
        send_wait--;
        byte_ch.valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        byte_ch.valid     <= 1'b1;
        byte_ch.text_byte <= text_q.pop_front();
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk_i) begin
    glyph_res_t want;
    if (!rst_ni) begin
      glyph_ch.ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (glyph_ch.valid && glyph_ch.ready) begin
        if (glyph_expect_q.size() == 0) begin
          $display("%0t: result with none expected, code_point %0h text_end %0b",
                   $time, glyph_ch.code_point, glyph_ch.text_end);
          errors++;
        end else begin
          want = glyph_expect_q.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(glyph_ch.code_point));
          check_field("glyph_found", 32'(want.glyph_found), 32'(glyph_ch.glyph_found));
          check_field("glyph_index", 32'(want.glyph_index), 32'(glyph_ch.glyph_index));
          check_field("text_end", 32'(want.text_end), 32'(glyph_ch.text_end));
          check_field("last_of_run", 32'(want.last_of_run), 32'(glyph_ch.last_of_run));
        end
        recv_wait = recv_gaps_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall_requests != stalls_served) begin
        stalls_served++;
        hold_left = LongStall;
      end
      if (hold_left > 0) begin
        hold_left--;
        glyph_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        glyph_ch.ready <= 1'b0;
      end else begin
        glyph_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (glyph_ch.valid && glyph_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CpW-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      RegPrimaryFirst: range_cfg.primary_first = val;
      RegPrimaryLast:  range_cfg.primary_last = val;
      RegRangeAFirst:  range_cfg.range_first[0] = val;
      RegRangeALast:   range_cfg.range_last[0] = val;
      RegRangeABase:   range_cfg.range_base[0] = val[IdxW-1:0];
      RegRangeBFirst:  range_cfg.range_first[1] = val;
      RegRangeBLast:   range_cfg.range_last[1] = val;
      RegRangeBBase:   range_cfg.range_base[1] = val[IdxW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_ranges(input logic [CpW-1:0] pf, pl, af, al, ab, bf, bl, bb);
    write_reg(RegPrimaryFirst, pf);
    write_reg(RegPrimaryLast, pl);
    write_reg(RegRangeAFirst, af);
    write_reg(RegRangeALast, al);
    write_reg(RegRangeABase, ab);
    write_reg(RegRangeBFirst, bf);
    write_reg(RegRangeBLast, bl);
    write_reg(RegRangeBBase, bb);
  endtask

  task automatic random_ranges();
    logic [CpW-1:0] f[3];
    logic [CpW-1:0] l[3];
    for (int r = 0; r < 3; r++) begin
      f[r] = ($urandom_range(0, 3) == 0) ? CpW'($urandom) : CpW'($urandom_range(0, 'h3000));
      l[r] = f[r] + CpW'($urandom_range(0, 'h400));
      if ($urandom_range(0, 5) == 0) l[r] = f[r] - CpW'(1);
    end
    write_ranges(f[0], l[0], f[1], l[1], CpW'($urandom), f[2], l[2], CpW'($urandom));
  endtask

  function automatic int unsigned min_len(logic [CpW-1:0] cp);
    if (cp < 'h80) return 1;
    if (cp < 'h800) return 2;
    if (cp < 'h10000) return 3;
    return 4;
  endfunction

  function automatic logic [CpW-1:0] pick_cp();
    logic [CpW-1:0] lo;
    logic [CpW-1:0] hi;
    case ($urandom_range(0, 5))
      0: return CpW'($urandom_range(1, 127));
      1: begin lo = range_cfg.primary_first;  hi = range_cfg.primary_last;  end
      2: begin lo = range_cfg.range_first[0]; hi = range_cfg.range_last[0]; end
      3: begin lo = range_cfg.range_first[1]; hi = range_cfg.range_last[1]; end
      4: return CpW'($urandom);
      default: return CpW'($urandom_range('h80, 'hFFFF));
    endcase
    if ($urandom_range(0, 1) == 1 && hi >= lo) return lo + CpW'($urandom_range(0, hi - lo));
    return (($urandom_range(0, 1) == 1) ? lo : hi) + CpW'($urandom_range(0, 4)) - CpW'(2);
  endfunction

  // encode cp in len bytes, queue only the first keep of them
  function automatic void push_cp(logic [CpW-1:0] cp, int unsigned len, int unsigned keep);
    logic [7:0] enc[4];
    enc[1] = ContTag | {2'b00, cp[5:0]};
    enc[2] = ContTag | {2'b00, cp[5:0]};
    enc[3] = ContTag | {2'b00, cp[5:0]};
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: enc[0] = Lead2Tag | {3'b000, cp[10:6]};
      3: begin
        enc[0] = Lead3Tag | {4'b0000, cp[15:12]};
        enc[1] = ContTag | {2'b00, cp[11:6]};
      end
      default: begin
        enc[0] = Lead4Tag | {5'b00000, cp[20:18]};
        enc[1] = ContTag | {2'b00, cp[17:12]};
        enc[2] = ContTag | {2'b00, cp[11:6]};
      end
    endcase
    for (int k = 0; k < keep; k++) text_q.push_back(enc[k]);
  endfunction

  function automatic void gen_text(int unsigned n);
    logic [CpW-1:0] cp;
    int unsigned len;
    int unsigned sel;
    while (text_q.size() < n) begin
      sel = $urandom_range(0, 99);
      cp  = pick_cp();
      len = min_len(cp);
      if (len < 4 && $urandom_range(0, 7) == 0) len = $urandom_range(len + 1, 4);
      if (len == 1 && cp == '0) len = 2;
      if (sel < 70) begin
        push_cp(cp, len, len);
      end else if (sel < 78) begin
        if (len == 1) len = $urandom_range(2, 4);
        push_cp(cp, len, $urandom_range(1, len - 1));
      end else if (sel < 84) begin
        text_q.push_back(ContTag | 8'($urandom_range(0, 63)));
      end else if (sel < 88) begin
        text_q.push_back(8'($urandom_range('hF8, 'hFF)));
      end else if (sel < 93) begin
        text_q.push_back(8'h00);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    text_q.push_back(8'h00);
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (text_q.size() != 0 || byte_ch.valid || glyph_expect_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input bit send_on, input bit recv_on, input bit hold,
                           input int unsigned n);
    @(negedge clk_i);
    send_gaps_on = send_on;
    recv_gaps_on = recv_on;
    if (hold) stall_requests++;
    gen_text(n);
    wait_idle();
  endtask

  initial begin
    range_cfg.primary_first  = CpW'(32);
    range_cfg.primary_last   = CpW'(126);
    range_cfg.range_first[0] = CpW'(1);
    range_cfg.range_last[0]  = '0;
    range_cfg.range_base[0]  = '0;
    range_cfg.range_first[1] = CpW'(1);
    range_cfg.range_last[1]  = '0;
    range_cfg.range_base[1]  = '0;
    cont_left = '0;
    cp_accum  = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.text_byte = '0;
    glyph_ch.ready    = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset ranges: ascii, stray bytes, interrupted and overlong sequences, max codepoint
    text_q = {8'h41, 8'h7E, 8'h7F, 8'hE2, 8'h82, 8'hAC, 8'hC0, 8'h80, 8'h80, 8'hF8, 8'hFF,
              8'hE2, 8'h41, 8'hC3, 8'h00, 8'hC3, 8'hE2, 8'h82, 8'hAC,
              8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00};
    wait_idle();

    // uppercase-only primary, so lowercase folds; range B wraps the glyph index
    write_ranges('h41, 'h5A, 'h80, 'h2FF, 100, 'h2000, 'h20FF, 'hFFF0);
    @(negedge clk_i);
    text_q = {8'h61, 8'h7A, 8'h60, 8'h7B, 8'h41, 8'h00};
    run_phase(1'b1, 1'b1, 1'b0, 250);

    // full primary, range A empty, oversized base write, unused index
    write_ranges('0, 'h1FFFFF, 'h1FFFFF, '0, 'h1ABCD, 'h100, 'h1FF, 'hFFFF);
    write_reg(RegUnused, 'h1FFFFF);
    run_phase(1'b0, 1'b0, 1'b0, 250);

    // primary empty, range A covers everything; receiver holds off while bytes keep coming
    write_ranges('h1FFFFF, '0, '0, 'h1FFFFF, '0, 'h41, 'h7A, 'h1234);
    run_phase(1'b0, 1'b1, 1'b1, 250);

    // range A shadows the case fold
    write_ranges('h20, 'h60, 'h60, 'h7F, 5, 'h7FF, 'h800, '0);
    run_phase(1'b1, 1'b0, 1'b0, 250);

    random_ranges();
    run_phase(1'b1, 1'b1, 1'b0, 250);
    random_ranges();
    run_phase(1'b0, 1'b1, 1'b0, 250);
    random_ranges();
    run_phase(1'b1, 1'b0, 1'b0, 250);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ugl_pkg.sv
src/ugl_ifs.sv
src/ugl_front.sv
src/ugl_fifo.sv
src/ugl_back.sv
src/utf8_decode_glyph_lookup.sv
dv/utf8_decode_glyph_lookup_test.sv
